/* rtl/top_k_top_p_token_sampler_core_macros.svh */
// Assertion macros shared by the token sampler RTL.
`ifndef TOP_K_TOP_P_TOKEN_SAMPLER_CORE_MACROS_SVH
`define TOP_K_TOP_P_TOKEN_SAMPLER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define TKS_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("token sampler assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define TKS_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("token sampler assertion failed");
`else
`define TKS_ASSERT_NOW(lbl, ant, cons)
`define TKS_ASSERT_NXT(lbl, ant, cons)
`endif
`endif

/* rtl/tks_pkg.sv */
// Package of constants, register codes and tables for the token sampler.
package tks_pkg;

  // Default vocabulary capacity.
  localparam int TKS_VOCAB_MAX = 32768;

  // Number of distinct Q0.16 probability levels (histogram buckets).
  localparam int TKS_PROB_LEVELS = 65536;

  // Configuration register indexes.
  localparam logic [1:0] TKS_REG_TEMPERATURE = 2'd0;
  localparam logic [1:0] TKS_REG_TOP_P       = 2'd1;
  localparam logic [1:0] TKS_REG_TOP_K       = 2'd2;

  // Register reset values.
  localparam logic [15:0] TKS_TEMP_RST  = 16'd0;
  localparam logic [16:0] TKS_TOP_P_RST = 17'd62259;
  localparam logic [15:0] TKS_TOP_K_RST = 16'd40;

  // 2^(-2^-(j+1)) in Q16 for fraction bit j, most significant first.
  function automatic logic [15:0] tks_pow2_frac(input logic [3:0] j);
    logic [15:0] v;
    unique case (j)
      4'd0:    v = 16'd46341;
      4'd1:    v = 16'd55109;
      4'd2:    v = 16'd60097;
      4'd3:    v = 16'd62757;
      4'd4:    v = 16'd64132;
      4'd5:    v = 16'd64830;
      4'd6:    v = 16'd65182;
      4'd7:    v = 16'd65359;
      4'd8:    v = 16'd65447;
      4'd9:    v = 16'd65492;
      4'd10:   v = 16'd65514;
      4'd11:   v = 16'd65525;
      4'd12:   v = 16'd65530;
      4'd13:   v = 16'd65533;
      4'd14:   v = 16'd65535;
      default: v = 16'd65535;
    endcase
    return v;
  endfunction

endpackage

/* rtl/tks_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module tks_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/tks_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module tks_div #(
  parameter int DVD_W = 48,
  parameter int DVS_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // Shift in the next dividend bit and try a subtraction.
  always_comb begin
    trial = {rem_r, quo_r[DVD_W-1]};
    ge    = trial >= {1'b0, dvs_r};
    diff  = trial - {1'b0, dvs_r};
  end

  // Step control.
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

/* rtl/top_k_top_p_token_sampler_core.sv */
// Top level of the top-k / top-p token sampler core.
// Logits stream in one per cycle while in_tready is high; each of the first
// VOCAB_MAX is stored and the first-index argmax is tracked. The transaction
// with in_tlast set ends the vocabulary and starts the sampling run, during
// which in_tready is low. With temperature 0 the argmax token goes from S_START
// through S_FIN to the output register. Otherwise the run clears the
// probability histogram memory, computes each weight and probability in the
// shared divider, one quotient bit per cycle (DVD_W is its width, 48 for 32768
// logits), builds the sorted order offsets bucket by bucket, places the tokens
// in order, and walks the nucleus once for the cut and once for the draw. The
// next vocabulary may stream in while the result still waits on out_tready.
module top_k_top_p_token_sampler_core #(
  parameter int VOCAB_MAX = tks_pkg::TKS_VOCAB_MAX
) (
  input  logic        clk,
  input  logic        rst_n,
  // Logit stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] logit, [31:16] random_fraction
  input  logic        in_tlast,   // last_logit
  // Token result.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [14:0] token_id, [15] zero
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import tks_pkg::*;

  localparam int IDX_W = $clog2(VOCAB_MAX);
  localparam int CNT_W = $clog2(VOCAB_MAX + 1);
  localparam int SUM_W = IDX_W + 17;
  localparam int DVS_W = SUM_W;
  localparam int DVD_W = (SUM_W + 16 > 36) ? SUM_W + 16 : 36;
  localparam int KC_W  = (CNT_W > 16) ? CNT_W : 16;
  localparam int LVL_W = $clog2(TKS_PROB_LEVELS);

  typedef enum logic [28:0] {
    S_LOAD   = 29'd1 << 0,
    S_START  = 29'd1 << 1,
    S_CLR    = 29'd1 << 2,
    S_W_RD   = 29'd1 << 3,
    S_W_DIV0 = 29'd1 << 4,
    S_W_DIV  = 29'd1 << 5,
    S_W_MUL  = 29'd1 << 6,
    S_W_EXP0 = 29'd1 << 7,
    S_W_POW  = 29'd1 << 8,
    S_W_RND  = 29'd1 << 9,
    S_W_ST   = 29'd1 << 10,
    S_P_RD   = 29'd1 << 11,
    S_P_DIV0 = 29'd1 << 12,
    S_P_DIV  = 29'd1 << 13,
    S_P_HIST = 29'd1 << 14,
    S_P_INC  = 29'd1 << 15,
    S_X_RD   = 29'd1 << 16,
    S_X_WR   = 29'd1 << 17,
    S_L_RD   = 29'd1 << 18,
    S_L_BK   = 29'd1 << 19,
    S_L_WR   = 29'd1 << 20,
    S_C_RD   = 29'd1 << 21,
    S_C_PR   = 29'd1 << 22,
    S_C_AC   = 29'd1 << 23,
    S_R_MUL  = 29'd1 << 24,
    S_S_RD   = 29'd1 << 25,
    S_S_PR   = 29'd1 << 26,
    S_S_AC   = 29'd1 << 27,
    S_FIN    = 29'd1 << 28
  } tks_state_t;

  tks_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic signed [15:0] max_logit_r, max_logit_nxt;
  logic [IDX_W-1:0]   max_idx_r, max_idx_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [15:0]        rf_r, rf_nxt;
  logic [15:0]        temp_r, temp_nxt;
  logic [16:0]        top_p_r, top_p_nxt;
  logic [15:0]        top_k_r, top_k_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [LVL_W-1:0]   b_r, b_nxt;
  logic [CNT_W-1:0]   run_r, run_nxt;
  logic [15:0]        p_r, p_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [37:0]        prod_r, prod_nxt;
  logic [21:0]        y_r, y_nxt;
  logic [30:0]        acc_r, acc_nxt;
  logic [3:0]         j_r, j_nxt;
  logic [16:0]        w_r, w_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SUM_W-1:0]   cum_r, cum_nxt;
  logic [SUM_W-1:0]   pcum_r, pcum_nxt;
  logic [16:0]        top_r, top_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [CNT_W-1:0]   cut_r, cut_nxt;
  logic [DVD_W-1:0]   rprod_r, rprod_nxt;
  logic [IDX_W-1:0]   tok_r, tok_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [14:0]        out_data_r, out_data_nxt;

  // Memory ports.
  logic               lg_we;
  logic [IDX_W-1:0]   lg_waddr, lg_raddr;
  logic [15:0]        lg_wdata, lg_rdata;
  logic               wt_we;
  logic [IDX_W-1:0]   wt_waddr, wt_raddr;
  logic [16:0]        wt_wdata, wt_rdata;
  logic               pr_we;
  logic [IDX_W-1:0]   pr_waddr, pr_raddr;
  logic [15:0]        pr_wdata, pr_rdata;
  logic               od_we;
  logic [IDX_W-1:0]   od_waddr, od_raddr;
  logic [IDX_W-1:0]   od_wdata, od_rdata;
  logic               bk_we;
  logic [LVL_W-1:0]   bk_waddr, bk_raddr;
  logic [CNT_W-1:0]   bk_wdata, bk_rdata;

  // Shared divider.
  logic               div_start;
  logic [DVD_W-1:0]   div_dividend;
  logic [DVS_W-1:0]   div_divisor;
  logic               div_busy;
  logic [DVD_W-1:0]   div_quo;

  // Datapath helpers.
  logic               in_acc;
  logic signed [15:0] in_logit;
  logic [CNT_W-1:0]   count_inc;
  logic [16:0]        lg_diff;
  logic [4:0]         ip_rnd;
  logic [31:0]        rnd_sum;
  logic [46:0]        pow_prod;
  logic [SUM_W-1:0]   cum_add;
  logic [SUM_W-1:0]   pcum_add;
  logic [DVD_W-1:0]   pcum_scaled;
  logic [CNT_W-1:0]   i_inc;

  assign in_acc    = in_tvalid && in_tready;
  assign in_logit  = signed'(in_tdata[15:0]);
  assign in_tready = (state_r == S_LOAD);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

  assign count_inc = CNT_W'(count_r + 1'b1);
  assign i_inc     = CNT_W'(i_r + 1'b1);
  assign lg_diff   = {max_logit_r[15], max_logit_r} - {lg_rdata[15], lg_rdata};
  assign ip_rnd    = y_r[20:16];
  assign rnd_sum   = {1'b0, acc_r} + (32'd1 << ({1'b0, ip_rnd} + 6'd13));
  assign pow_prod  = 47'(acc_r) * 47'(tks_pow2_frac(j_r));
  assign cum_add   = cum_r + SUM_W'(pr_rdata);
  assign pcum_add  = pcum_r + SUM_W'(pr_rdata);
  // Running sum times 65535, as a shift and a subtraction.
  assign pcum_scaled = DVD_W'({pcum_add, 16'd0}) - DVD_W'(pcum_add);

  // Configuration register writes.
  always_comb begin
    temp_nxt  = temp_r;
    top_p_nxt = top_p_r;
    top_k_nxt = top_k_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        TKS_REG_TEMPERATURE: temp_nxt  = cfg_data[15:0];
        TKS_REG_TOP_P:       top_p_nxt = cfg_data;
        TKS_REG_TOP_K:       top_k_nxt = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    max_logit_nxt = max_logit_r;
    max_idx_nxt   = max_idx_r;
    n_nxt         = n_r;
    rf_nxt        = rf_r;
    i_nxt         = i_r;
    b_nxt         = b_r;
    run_nxt       = run_r;
    p_nxt         = p_r;
    idx_nxt       = idx_r;
    prod_nxt      = prod_r;
    y_nxt         = y_r;
    acc_nxt       = acc_r;
    j_nxt         = j_r;
    w_nxt         = w_r;
    sum_nxt       = sum_r;
    cum_nxt       = cum_r;
    pcum_nxt      = pcum_r;
    top_nxt       = top_r;
    k_nxt         = k_r;
    cut_nxt       = cut_r;
    rprod_nxt     = rprod_r;
    tok_nxt       = tok_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    lg_we = 1'b0;  lg_waddr = count_r[IDX_W-1:0];  lg_wdata = in_logit;
    lg_raddr = i_r[IDX_W-1:0];
    wt_we = 1'b0;  wt_waddr = i_r[IDX_W-1:0];  wt_wdata = w_r;
    wt_raddr = i_r[IDX_W-1:0];
    pr_we = 1'b0;  pr_waddr = i_r[IDX_W-1:0];  pr_wdata = p_r;
    pr_raddr = i_r[IDX_W-1:0];
    od_we = 1'b0;  od_waddr = bk_rdata[IDX_W-1:0];  od_wdata = i_r[IDX_W-1:0];
    od_raddr = i_r[IDX_W-1:0];
    bk_we = 1'b0;  bk_waddr = b_r;  bk_wdata = '0;
    bk_raddr = b_r;

    div_start    = 1'b0;
    div_dividend = DVD_W'({lg_diff[15:0], 20'd0});
    div_divisor  = DVS_W'(temp_r);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (count_r < CNT_W'(VOCAB_MAX)) begin
            lg_we = 1'b1;
            if (count_r == '0 || in_logit > max_logit_r) begin
              max_logit_nxt = in_logit;
              max_idx_nxt   = count_r[IDX_W-1:0];
            end
            count_nxt = count_inc;
          end
          if (in_tlast) begin
            n_nxt     = (count_r < CNT_W'(VOCAB_MAX)) ? count_inc : count_r;
            count_nxt = '0;
            rf_nxt    = in_tdata[31:16];
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        top_nxt = (top_p_r > 17'd65536) ? 17'd65536 : top_p_r;
        k_nxt   = (top_k_r == '0 || KC_W'(top_k_r) > KC_W'(n_r)) ? n_r : CNT_W'(top_k_r);
        sum_nxt = '0;
        i_nxt   = '0;
        b_nxt   = '0;
        if (temp_r == '0) begin
          tok_nxt   = max_idx_r;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CLR;
        end
      end
      // Clear the histogram, one bucket a cycle.
      S_CLR: begin
        bk_we = 1'b1;
        b_nxt = LVL_W'(b_r + 1'b1);
        if (b_r == {LVL_W{1'b1}}) begin
          state_nxt = S_W_RD;
        end
      end
      // Weight pass: w = 2^-((max-logit)/temp * log2(e)).
      S_W_RD: begin
        state_nxt = S_W_DIV0;
      end
      S_W_DIV0: begin
        div_start = 1'b1;
        state_nxt = S_W_DIV;
      end
      S_W_DIV: begin
        if (!div_busy) begin
          state_nxt = S_W_MUL;
        end
      end
      S_W_MUL: begin
        if (|div_quo[DVD_W-1:20]) begin
          w_nxt     = '0;
          state_nxt = S_W_ST;
        end else begin
          prod_nxt  = 38'(div_quo[19:0]) * 38'd94548 + 38'd32768;
          state_nxt = S_W_EXP0;
        end
      end
      S_W_EXP0: begin
        y_nxt = prod_r[37:16];
        if (prod_r[37:32] >= 6'd17) begin
          w_nxt     = '0;
          state_nxt = S_W_ST;
        end else begin
          acc_nxt   = 31'd1 << 30;
          j_nxt     = '0;
          state_nxt = S_W_POW;
        end
      end
      S_W_POW: begin
        if (y_r[4'd15 - j_r]) begin
          acc_nxt = pow_prod[46:16];
        end
        j_nxt = j_r + 1'b1;
        if (j_r == 4'd15) begin
          state_nxt = S_W_RND;
        end
      end
      S_W_RND: begin
        w_nxt     = 17'(rnd_sum >> ({1'b0, ip_rnd} + 6'd14));
        state_nxt = S_W_ST;
      end
      S_W_ST: begin
        wt_we   = 1'b1;
        sum_nxt = sum_r + SUM_W'(w_r);
        i_nxt   = i_inc;
        if (i_inc == n_r) begin
          i_nxt     = '0;
          state_nxt = S_P_RD;
        end else begin
          state_nxt = S_W_RD;
        end
      end
      // Probability pass with histogram count.
      S_P_RD: begin
        state_nxt = S_P_DIV0;
      end
      S_P_DIV0: begin
        div_start    = 1'b1;
        div_dividend = DVD_W'({wt_rdata, 16'd0});
        div_divisor  = sum_r;
        state_nxt    = S_P_DIV;
      end
      S_P_DIV: begin
        if (!div_busy) begin
          state_nxt = S_P_HIST;
        end
      end
      S_P_HIST: begin
        p_nxt     = (|div_quo[DVD_W-1:16]) ? 16'hFFFF : div_quo[15:0];
        pr_we     = 1'b1;
        pr_wdata  = p_nxt;
        bk_raddr  = p_nxt;
        state_nxt = S_P_INC;
      end
      S_P_INC: begin
        bk_we    = 1'b1;
        bk_waddr = p_r;
        bk_wdata = CNT_W'(bk_rdata + 1'b1);
        i_nxt    = i_inc;
        if (i_inc == n_r) begin
          b_nxt     = {LVL_W{1'b1}};
          run_nxt   = '0;
          state_nxt = S_X_RD;
        end else begin
          state_nxt = S_P_RD;
        end
      end
      // Bucket offsets, highest probability first.
      S_X_RD: begin
        state_nxt = S_X_WR;
      end
      S_X_WR: begin
        bk_we    = 1'b1;
        bk_wdata = run_r;
        run_nxt  = CNT_W'(run_r + bk_rdata);
        b_nxt    = LVL_W'(b_r - 1'b1);
        if (b_r == '0) begin
          i_nxt     = '0;
          state_nxt = S_L_RD;
        end else begin
          state_nxt = S_X_RD;
        end
      end
      // Place each token at its bucket offset.
      S_L_RD: begin
        state_nxt = S_L_BK;
      end
      S_L_BK: begin
        p_nxt     = pr_rdata;
        bk_raddr  = pr_rdata;
        state_nxt = S_L_WR;
      end
      S_L_WR: begin
        od_we    = 1'b1;
        bk_we    = 1'b1;
        bk_waddr = p_r;
        bk_wdata = CNT_W'(bk_rdata + 1'b1);
        i_nxt    = i_inc;
        if (i_inc == n_r) begin
          i_nxt     = '0;
          cum_nxt   = '0;
          state_nxt = S_C_RD;
        end else begin
          state_nxt = S_L_RD;
        end
      end
      // Find the nucleus cut.
      S_C_RD: begin
        state_nxt = S_C_PR;
      end
      S_C_PR: begin
        pr_raddr  = od_rdata;
        state_nxt = S_C_AC;
      end
      S_C_AC: begin
        cum_nxt = cum_add;
        if (cum_add >= SUM_W'(top_r) || top_r == '0 || i_inc == k_r) begin
          cut_nxt   = i_r;
          state_nxt = S_R_MUL;
        end else begin
          i_nxt     = i_inc;
          state_nxt = S_C_RD;
        end
      end
      // Scale the random draw by the nucleus mass. The running sum reaches the
      // rounded-up draw exactly when 65535 times the sum reaches this product.
      S_R_MUL: begin
        rprod_nxt = DVD_W'(rf_r) * DVD_W'(cum_r);
        i_nxt     = '0;
        pcum_nxt  = '0;
        state_nxt = S_S_RD;
      end
      // Walk the nucleus until the running sum reaches the draw.
      S_S_RD: begin
        state_nxt = S_S_PR;
      end
      S_S_PR: begin
        idx_nxt   = od_rdata;
        pr_raddr  = od_rdata;
        state_nxt = S_S_AC;
      end
      S_S_AC: begin
        pcum_nxt = pcum_add;
        if (pcum_scaled >= rprod_r || i_r == cut_r) begin
          tok_nxt   = idx_r;
          state_nxt = S_FIN;
        end else begin
          i_nxt     = i_inc;
          state_nxt = S_S_RD;
        end
      end
      // Load the output register once it is free.
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = 15'(tok_r);
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      max_logit_r <= '0;
      max_idx_r   <= '0;
      temp_r      <= TKS_TEMP_RST;
      top_p_r     <= TKS_TOP_P_RST;
      top_k_r     <= TKS_TOP_K_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      max_logit_r <= max_logit_nxt;
      max_idx_r   <= max_idx_nxt;
      temp_r      <= temp_nxt;
      top_p_r     <= top_p_nxt;
      top_k_r     <= top_k_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    rf_r       <= rf_nxt;
    i_r        <= i_nxt;
    b_r        <= b_nxt;
    run_r      <= run_nxt;
    p_r        <= p_nxt;
    idx_r      <= idx_nxt;
    prod_r     <= prod_nxt;
    y_r        <= y_nxt;
    acc_r      <= acc_nxt;
    j_r        <= j_nxt;
    w_r        <= w_nxt;
    sum_r      <= sum_nxt;
    cum_r      <= cum_nxt;
    pcum_r     <= pcum_nxt;
    top_r      <= top_nxt;
    k_r        <= k_nxt;
    cut_r      <= cut_nxt;
    rprod_r    <= rprod_nxt;
    tok_r      <= tok_nxt;
    out_data_r <= out_data_nxt;
  end

  // Stores for logits, weights, probabilities, sorted order and histogram.
  tks_ram #(.WIDTH(16), .DEPTH(VOCAB_MAX)) u_logit_ram (
    .clk(clk), .we(lg_we), .waddr(lg_waddr), .wdata(lg_wdata),
    .raddr(lg_raddr), .rdata(lg_rdata)
  );

  tks_ram #(.WIDTH(17), .DEPTH(VOCAB_MAX)) u_weight_ram (
    .clk(clk), .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
    .raddr(wt_raddr), .rdata(wt_rdata)
  );

  tks_ram #(.WIDTH(16), .DEPTH(VOCAB_MAX)) u_prob_ram (
    .clk(clk), .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
    .raddr(pr_raddr), .rdata(pr_rdata)
  );

  tks_ram #(.WIDTH(IDX_W), .DEPTH(VOCAB_MAX)) u_order_ram (
    .clk(clk), .we(od_we), .waddr(od_waddr), .wdata(od_wdata),
    .raddr(od_raddr), .rdata(od_rdata)
  );

  tks_ram #(.WIDTH(CNT_W), .DEPTH(TKS_PROB_LEVELS)) u_bucket_ram (
    .clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
    .raddr(bk_raddr), .rdata(bk_rdata)
  );

  tks_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .busy(div_busy), .quotient(div_quo)
  );

  // Design checks.
`include "top_k_top_p_token_sampler_core_macros.svh"

  `TKS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(VOCAB_MAX))
  `TKS_ASSERT_NOW(a_div_idle_start, div_start, !div_busy)
  `TKS_ASSERT_NOW(a_cut_in_k, state_r == S_C_AC, i_r < k_r)
  `TKS_ASSERT_NOW(a_sample_in_cut, state_r == S_S_AC, i_r <= cut_r)
  `TKS_ASSERT_NXT(a_fin_loads_out, state_r == S_FIN && state_nxt == S_LOAD, out_valid_r)

endmodule
